>>> src/etok_pkg.sv
// Shared types, character codes and classification helpers for the
// expression tokenizer. No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package etok_pkg;

  // Offset counter width and width of the reported offset fields
  localparam int PosBits   = 16;
  localparam int FieldBits = 16;
  localparam int FieldMax  = (2 ** FieldBits) - 1;

  typedef logic [PosBits-1:0]   pos_t;
  typedef logic [FieldBits-1:0] field_t;

  // Token kinds as reported on the result channel
  typedef enum logic [3:0] {
    KIND_NUMBER  = 4'd0,
    KIND_IDENT   = 4'd1,
    KIND_PLUS    = 4'd2,
    KIND_MINUS   = 4'd3,
    KIND_STAR    = 4'd4,
    KIND_SLASH   = 4'd5,
    KIND_PERCENT = 4'd6,
    KIND_CARET   = 4'd7,
    KIND_BANG    = 4'd8,
    KIND_LPAREN  = 4'd9,
    KIND_RPAREN  = 4'd10,
    KIND_COMMA   = 4'd11,
    KIND_END     = 4'd12,
    KIND_INVALID = 4'd13
  } kind_t;

  // Pending token being scanned
  typedef enum logic [1:0] {
    SCAN_NONE   = 2'd0,
    SCAN_NUMBER = 2'd1,
    SCAN_IDENT  = 2'd2
  } scan_mode_t;

  // Character codes
  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChBang    = 8'h21;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChLParen  = 8'h28;
  localparam logic [7:0] ChRParen  = 8'h29;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChUpperZ  = 8'h5A;
  localparam logic [7:0] ChCaret   = 8'h5E;
  localparam logic [7:0] ChUnder   = 8'h5F;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] ChLowerZ  = 8'h7A;

  // One result item
  typedef struct packed {
    kind_t  kind;
    field_t start;
    field_t length;
    logic   last;
  } token_t;

  // Results produced by one scanned byte, handed to the output queue
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_digit(c) || ((c >= ChLowerA) && (c <= ChLowerZ)) ||
           ((c >= ChUpperA) && (c <= ChUpperZ)) || (c == ChUnder);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic kind_t op_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      ChPlus:    k = KIND_PLUS;
      ChMinus:   k = KIND_MINUS;
      ChStar:    k = KIND_STAR;
      ChSlash:   k = KIND_SLASH;
      ChPercent: k = KIND_PERCENT;
      ChCaret:   k = KIND_CARET;
      ChBang:    k = KIND_BANG;
      ChLParen:  k = KIND_LPAREN;
      ChRParen:  k = KIND_RPAREN;
      ChComma:   k = KIND_COMMA;
      default:   k = KIND_INVALID;
    endcase
    return k;
  endfunction

  // Saturate an offset to the reported field width
  function automatic field_t clip_field(input pos_t v);
    logic [PosBits+FieldBits-1:0] w;
    w = (PosBits + FieldBits)'(v);
    if (w > (PosBits + FieldBits)'(FieldMax)) begin
      return '1;
    end
    return w[FieldBits-1:0];
  endfunction

endpackage

>>> src/etok_scan.sv
// Scanner core: holds the lexer state and turns one text byte into up to
// two tokens per cycle in which fire is high. Depends on etok_pkg.
`timescale 1ns / 1ps

module etok_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          text_byte,
  output etok_pkg::push_t     push
);
  import etok_pkg::*;

  scan_mode_t mode_r, mode_nxt;
  logic       dot_r, dot_nxt;
  pos_t       pstart_r, pstart_nxt;
  pos_t       pos_r, pos_nxt;

  logic   cont;
  logic   flush;
  logic   second;
  pos_t   pos_inc;
  token_t pend_tok;
  token_t new_tok;

  // Saturating position advance
  assign pos_inc = (pos_r == '1) ? pos_r : pos_r + 1'b1;

  // Decide whether the byte extends, ends or starts a token
  always_comb begin
    cont = ((mode_r == SCAN_NUMBER) &&
            (is_digit(text_byte) || ((text_byte == ChDot) && !dot_r))) ||
           ((mode_r == SCAN_IDENT) && is_word(text_byte));
    flush = ((mode_r == SCAN_NUMBER) || (mode_r == SCAN_IDENT)) && !cont;

    pend_tok.kind   = (mode_r == SCAN_NUMBER) ? KIND_NUMBER : KIND_IDENT;
    pend_tok.start  = clip_field(pstart_r);
    pend_tok.length = clip_field(pos_r - pstart_r);
    pend_tok.last   = 1'b0;

    new_tok.kind   = op_kind(text_byte);
    new_tok.start  = clip_field(pos_r);
    new_tok.length = field_t'(1);
    new_tok.last   = 1'b1;

    mode_nxt   = mode_r;
    dot_nxt    = dot_r;
    pstart_nxt = pstart_r;
    pos_nxt    = pos_inc;
    second     = 1'b0;

    if (cont) begin
      if ((mode_r == SCAN_NUMBER) && (text_byte == ChDot)) begin
        dot_nxt = 1'b1;
      end
    end else begin
      mode_nxt = SCAN_NONE;
      if (text_byte == ChNul) begin
        // End of text: emit end token, rewind the position
        new_tok.kind   = KIND_END;
        new_tok.start  = '0;
        new_tok.length = '0;
        second         = 1'b1;
        dot_nxt        = 1'b0;
        pos_nxt        = '0;
      end else if (is_digit(text_byte)) begin
        mode_nxt   = SCAN_NUMBER;
        dot_nxt    = 1'b0;
        pstart_nxt = pos_r;
      end else if (is_word(text_byte)) begin
        mode_nxt   = SCAN_IDENT;
        pstart_nxt = pos_r;
      end else if (!is_blank(text_byte)) begin
        second = 1'b1;
      end
    end

    // Pack the results in order, the final one carries the last flag
    push.tok1 = new_tok;
    if (flush) begin
      pend_tok.last = !second;
      push.tok0     = pend_tok;
      push.count    = second ? 2'd2 : 2'd1;
    end else begin
      push.tok0  = new_tok;
      push.count = second ? 2'd1 : 2'd0;
    end
    if (!fire) begin
      push.count = 2'd0;
    end
  end

  // Hold state until a byte is scanned
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= SCAN_NONE;
      dot_r    <= 1'b0;
      pstart_r <= '0;
      pos_r    <= '0;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      dot_r    <= dot_nxt;
      pstart_r <= pstart_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule

>>> src/etok_outq.sv
// Four-entry result queue: takes up to two tokens per cycle, gives one while out_ready is high.
// Depends on etok_pkg.
`timescale 1ns / 1ps

module etok_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  etok_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output etok_pkg::token_t  out_tok
);
  import etok_pkg::*;

  localparam int Depth = 4;
  localparam int AddrBits = $clog2(Depth);

  token_t                mem_r [Depth];
  logic [AddrBits-1:0]   wr_ptr_r, rd_ptr_r;
  logic [AddrBits:0]     cnt_r, cnt_nxt;
  logic                  pop;
  logic [AddrBits-1:0]   wr_ptr_p1;

  assign room      = cnt_r <= (AddrBits + 1)'(Depth - 2);
  assign out_valid = cnt_r != '0;
  assign out_tok   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;
  assign cnt_nxt   = cnt_r + (AddrBits + 1)'(push.count) - (AddrBits + 1)'(pop);

  // Store pushed tokens
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.tok0;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.tok1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + AddrBits'(push.count);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> src/expression_tokenizer_top.sv
// Top level of the expression tokenizer: input register, scanner and result queue.
// Depends on etok_pkg, etok_scan and etok_outq.
//
//  channel | dir | tdata              | tuser          | tlast
//  in_     | in  | [7:0] text_byte    | -              | -
//  out_    | out | [15:0] token_start | [3:0] kind     | last_of_run
//          |     | [31:16] token_len  |                |
//
// One byte is accepted per cycle while in_tready is high. A byte is held in the input
// register and scanned once the queue has room for two results; its results (zero, one
// or two) then enter the result queue, where the first result becomes visible. A byte that
// yields two results occupies the output for both results in turn, which is what sets the
// sustained rate in that case. Reset clears the scanner state and empties the queue.
// A stall on the output fills the queue and then holds off in_tready.
`timescale 1ns / 1ps

module expression_tokenizer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] token_start, [31:16] token_length
  output logic [3:0]  out_tuser,  // [3:0] token_kind
  output logic        out_tlast   // last_of_run
);
  import etok_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       room;
  logic       fire;
  push_t      push;
  token_t     out_tok;

  // Scan the held byte once the queue can take two results
  assign fire      = in_valid_r && room;
  assign in_tready = !in_valid_r || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  etok_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .text_byte (in_byte_r),
    .push      (push)
  );

  etok_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tok   (out_tok)
  );

  // Drive the result channel
  assign out_tdata = {out_tok.length, out_tok.start};
  assign out_tuser = out_tok.kind;
  assign out_tlast = out_tok.last;

endmodule

>>> src/etok_check.sv
// Port-level checker for the expression tokenizer, bound to the top level.
// Depends on etok_pkg and expression_tokenizer_top.
`timescale 1ns / 1ps

module etok_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [3:0]  out_tuser,
  input logic        out_tlast
);
  import etok_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // End token always closes its run
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_END) |-> out_tlast)
    else $error("end token without last flag");

  // End token has zero offset and length
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_END) |-> out_tdata == '0)
    else $error("end token with nonzero fields");

  // Single-character tokens have length one and end their run
  a_op_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != KIND_NUMBER) && (out_tuser != KIND_IDENT) &&
    (out_tuser != KIND_END) |-> (out_tdata[31:16] == 16'd1) && out_tlast)
    else $error("bad single-character token");

  // Input is held off only while results are waiting
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

endmodule

bind expression_tokenizer_top etok_check u_etok_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
